>>> rtl/deq_pkg.sv
// Shared types and constants for the double-ended byte ring buffer.
package deq_pkg;

   // Beat field widths
   localparam int OPCODE_W = 3;
   localparam int OFFSET_W = 4;
   localparam int VALUE_W  = 8;
   localparam int DATA_W   = 8;
   localparam int COUNT_W  = 4;

   // Default geometry
   localparam int DEF_DEPTH     = 16;
   localparam int DEF_DATA_BITS = 8;

   // Operation codes
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_GET        = 3'd4,
      OP_SET        = 3'd5
   } op_type;

   // Slot store access request from the index unit
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

>>> rtl/deq_ram.sv
// Generic single-port RAM with registered read data.
module deq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/deq_index.sv
// Head and tail index unit: decodes the operation and drives the slot store access.
module deq_index #(
   parameter int DEPTH = deq_pkg::DEF_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [deq_pkg::OPCODE_W-1:0]   opcode,
   input  logic [deq_pkg::OFFSET_W-1:0]   offset,
   output logic [$clog2(DEPTH)-1:0]       mem_addr,
   output deq_pkg::mem_ctl_type           mem_ctl,
   output logic [deq_pkg::COUNT_W-1:0]    count_next
);
   import deq_pkg::*;

   localparam int IDX_BITS = $clog2(DEPTH);

   logic [IDX_BITS-1:0]          head_ff, head_in;
   logic [IDX_BITS-1:0]          tail_ff, tail_in;
   logic [IDX_BITS-1:0]          head_inc, head_dec, tail_inc, tail_dec;
   logic [IDX_BITS-1:0]          live;
   logic [IDX_BITS+OFFSET_W-1:0] pos_sum;
   logic [IDX_BITS+COUNT_W-1:0]  live_ext;
   logic                         empty;

   assign head_inc = head_ff + 1'b1;
   assign head_dec = head_ff - 1'b1;
   assign tail_inc = tail_ff + 1'b1;
   assign tail_dec = tail_ff - 1'b1;
   assign empty    = (head_ff == tail_ff);
   // slot at offset from head, wrapped to the store depth
   assign pos_sum  = {{OFFSET_W{1'b0}}, head_ff} + {{IDX_BITS{1'b0}}, offset};

   // Operation decode
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      mem_addr = tail_ff;
      mem_ctl  = '0;
      unique case (opcode)
         OP_PUSH_BACK: begin
            mem_addr       = tail_ff;
            mem_ctl.wr_en  = 1'b1;
            tail_in        = tail_inc;
            // full: drop the oldest front entry
            if (tail_inc == head_ff) begin
               head_in = head_inc;
            end
         end
         OP_PUSH_FRONT: begin
            mem_addr       = head_dec;
            mem_ctl.wr_en  = 1'b1;
            head_in        = head_dec;
            // full: drop the last entry
            if (head_dec == tail_ff) begin
               tail_in = tail_dec;
            end
         end
         OP_POP_BACK: begin
            mem_addr = tail_dec;
            if (!empty) begin
               mem_ctl.rd_en = 1'b1;
               tail_in       = tail_dec;
            end
         end
         OP_POP_FRONT: begin
            mem_addr = head_ff;
            if (!empty) begin
               mem_ctl.rd_en = 1'b1;
               head_in       = head_inc;
            end
         end
         OP_GET: begin
            mem_addr      = pos_sum[IDX_BITS-1:0];
            mem_ctl.rd_en = 1'b1;
         end
         OP_SET: begin
            mem_addr      = pos_sum[IDX_BITS-1:0];
            mem_ctl.wr_en = 1'b1;
         end
         default: begin
            mem_ctl = '0;
         end
      endcase
   end

   // Live count after the operation
   assign live       = tail_in - head_in;
   assign live_ext   = {{COUNT_W{1'b0}}, live};
   assign count_next = live_ext[COUNT_W-1:0];

   // Index registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else if (accept) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

endmodule

>>> rtl/double_ended_ring_buffer_byte.sv
// An accepted request beat waits in the pending stage, then in the result
// register. Throughput: one beat per cycle while rsp_stall is low; the slot
// store is read and written at the accept edge and its registered read data
// feeds the result register. With one port, a beat touches at most one slot.
// Reset clears head, tail and all valid flags; slot contents stay undefined.
// Top level: double-ended ring buffer of bytes with a result pipeline.
module double_ended_ring_buffer_byte #(
   parameter int DEPTH     = deq_pkg::DEF_DEPTH,
   parameter int DATA_BITS = deq_pkg::DEF_DATA_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [deq_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [deq_pkg::OFFSET_W-1:0] req_offset,
   input  logic [deq_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [deq_pkg::DATA_W-1:0]   rsp_data,
   output logic [deq_pkg::COUNT_W-1:0]  rsp_count
);
   import deq_pkg::*;

   localparam int IDX_BITS = $clog2(DEPTH);

   logic                          accept;
   logic [IDX_BITS-1:0]           mem_addr;
   mem_ctl_type                   mem_ctl;
   logic [COUNT_W-1:0]            count_next;
   logic [DATA_BITS+VALUE_W-1:0]  value_ext;
   logic [DATA_BITS-1:0]          rdata;
   logic [DATA_BITS+DATA_W-1:0]   rdata_ext;

   logic                          p_valid_ff, p_valid_in;
   logic                          p_rd_ff;
   logic [COUNT_W-1:0]            p_count_ff;
   logic                          p_move;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]             rsp_data_ff;
   logic [COUNT_W-1:0]            rsp_count_ff;

   // Handshake
   assign p_move    = p_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = p_valid_ff && !p_move;
   assign accept    = req_valid && !req_stall;

   // Index unit
   deq_index #(
      .DEPTH(DEPTH)
   ) u_index (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (req_opcode),
      .offset     (req_offset),
      .mem_addr   (mem_addr),
      .mem_ctl    (mem_ctl),
      .count_next (count_next)
   );

   // Slot store
   assign value_ext = {{DATA_BITS{1'b0}}, req_value};

   deq_ram #(
      .WIDTH(DATA_BITS),
      .DEPTH(DEPTH)
   ) u_slots (
      .clock (clock),
      .wr_en (accept && mem_ctl.wr_en),
      .rd_en (accept && mem_ctl.rd_en),
      .addr  (mem_addr),
      .wdata (value_ext[DATA_BITS-1:0]),
      .rdata (rdata)
   );

   assign rdata_ext = {{DATA_W{1'b0}}, rdata};

   // Pending stage: waits for read data
   always_comb begin
      p_valid_in = p_valid_ff;
      if (accept) begin
         p_valid_in = 1'b1;
      end else if (p_move) begin
         p_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_rd_ff    <= mem_ctl.rd_en;
         p_count_ff <= count_next;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (p_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_move) begin
         rsp_data_ff  <= p_rd_ff ? rdata_ext[DATA_W-1:0] : '0;
         rsp_count_ff <= p_count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_count = rsp_count_ff;

endmodule

>>> dv/tb_double_ended_ring_buffer_byte.sv
// Testbench for the double-ended byte ring buffer: directed table, then random deque traffic.
module tb_double_ended_ring_buffer_byte;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam int DEPTH = DEF_DEPTH;
   localparam int IX_W  = $clog2(DEPTH);
   localparam int RANDOM_ITEMS = 466;
   localparam int SCRIPT_ROWS  = 21;

   // opcodes the block must ignore
   localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
   } answer_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic [OFFSET_W-1:0] off;
      logic [VALUE_W-1:0]  val;
      logic [4:0]          reps;
      logic                typed;
      answer_type          ans;
   } script_row_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OPCODE_W-1:0] req_opcode = '0;
   logic [OFFSET_W-1:0] req_offset = '0;
   logic [VALUE_W-1:0]  req_value  = '0;
   logic                rsp_valid;
   logic                rsp_stall  = 1'b0;
   logic [DATA_W-1:0]   rsp_data;
   logic [COUNT_W-1:0]  rsp_count;

   // deque image kept by the testbench
   logic [DATA_W-1:0] slot_img [DEPTH];
   bit                written  [DEPTH];
   logic [IX_W-1:0]   head_ix = '0;
   logic [IX_W-1:0]   tail_ix = '0;

   answer_type     owed_answers [$];
   script_row_type script [SCRIPT_ROWS];
   int             mismatches  = 0;
   logic           quiet_spell = 1'b0;
   int             hold_left   = 0;

   double_ended_ring_buffer_byte dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_opcode(req_opcode),
      .req_offset(req_offset),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .rsp_count (rsp_count)
   );

   always #5 clock = ~clock;

   // give up long after the slowest legal run
   initial begin
      #3ms;
      $display("FAILURE");
      $finish;
   end

   // alternate stretches with no idling and stretches with random gaps
   initial begin
      forever begin
         repeat ($urandom_range(50, 300)) @(posedge clock);
         quiet_spell <= !quiet_spell;
      end
   end

   function automatic logic [IX_W-1:0] live_entries();
      logic [IX_W-1:0] diff;
      diff = tail_ix - head_ix;
      return diff;
   endfunction

   // mostly short gaps, a few long ones, none in a quiet spell
   function automatic int pick_pause();
      int r;
      if (quiet_spell) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // apply one operation to the deque image and return the answer it yields
   function automatic answer_type apply_op(input logic [OPCODE_W-1:0] op,
                                           input logic [OFFSET_W-1:0] off,
                                           input logic [VALUE_W-1:0]  val);
      answer_type      ans;
      logic [IX_W-1:0] pos;
      ans.data = '0;
      pos = head_ix + off;
      case (op)
         OP_PUSH_BACK: begin
            slot_img[tail_ix] = val;
            written[tail_ix]  = 1'b1;
            tail_ix = tail_ix + 1'b1;
            // full: drop the oldest front entry
            if (tail_ix == head_ix) head_ix = head_ix + 1'b1;
         end
         OP_PUSH_FRONT: begin
            head_ix = head_ix - 1'b1;
            // full: drop the last back entry
            if (head_ix == tail_ix) tail_ix = tail_ix - 1'b1;
            slot_img[head_ix] = val;
            written[head_ix]  = 1'b1;
         end
         OP_POP_BACK: begin
            if (head_ix != tail_ix) begin
               tail_ix  = tail_ix - 1'b1;
               ans.data = slot_img[tail_ix];
            end
         end
         OP_POP_FRONT: begin
            if (head_ix != tail_ix) begin
               ans.data = slot_img[head_ix];
               head_ix  = head_ix + 1'b1;
            end
         end
         OP_GET: ans.data = slot_img[pos];
         OP_SET: begin
            slot_img[pos] = val;
            written[pos]  = 1'b1;
         end
         default: ;
      endcase
      ans.count = live_entries();
      return ans;
   endfunction

   function automatic script_row_type mk_row(input logic [OPCODE_W-1:0] op,
                                             input logic [OFFSET_W-1:0] off,
                                             input logic [VALUE_W-1:0] val, input int reps,
                                             input logic typed,
                                             input logic [DATA_W-1:0] data,
                                             input logic [COUNT_W-1:0] count);
      script_row_type row;
      row.op = op;
      row.off = off;
      row.val = val;
      row.reps = reps[4:0];
      row.typed = typed;
      row.ans.data = data;
      row.ans.count = count;
      return row;
   endfunction

   // present one request beat, record its answer at acceptance, then maybe idle
   task automatic offer_beat(input logic [OPCODE_W-1:0] op, input logic [OFFSET_W-1:0] off,
                             input logic [VALUE_W-1:0] val, input logic typed,
                             input answer_type typed_ans);
      answer_type ans;
      int         gap;
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_offset <= off;
      req_value  <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ans = apply_op(op, off, val);
      owed_answers.insert(owed_answers.size(), typed ? typed_ans : ans);
      gap = pick_pause();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // result side: check each accepted beat, then drive the next stall
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_answers.size() == 0) begin
            $display("%0t: result beat with none expected, data %0h count %0d",
                     $time, rsp_data, rsp_count);
            mismatches++;
         end else begin
            want = owed_answers.pop_front();
            if (rsp_data !== want.data) begin
               $display("%0t: data expected %0h got %0h", $time, want.data, rsp_data);
               mismatches++;
            end
            if (rsp_count !== want.count) begin
               $display("%0t: count expected %0d got %0d", $time, want.count, rsp_count);
               mismatches++;
            end
         end
      end
      if (hold_left == 0 && $urandom_range(0, 3) == 0) hold_left = pick_pause();
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // stimulus
   initial begin
      answer_type          row_ans;
      logic [OPCODE_W-1:0] op;
      logic [OFFSET_W-1:0] off;
      logic [VALUE_W-1:0]  val;
      logic [IX_W-1:0]     live;
      logic [IX_W-1:0]     pos;
      int                  pick;
      int                  real_items;
      int                  phase_left;
      bit                  fill_phase;

      foreach (written[i]) written[i] = 1'b0;

      // empty buffer, ignored opcodes, value extremes, get/set, then full wraparound
      script[0]  = mk_row(OP_POP_FRONT,  4'd0,  8'h00, 1,  1'b1, 8'h00, 4'd0);
      script[1]  = mk_row(OP_POP_BACK,   4'd0,  8'h00, 1,  1'b1, 8'h00, 4'd0);
      script[2]  = mk_row(OP_SPARE_A,    4'd15, 8'hFF, 1,  1'b1, 8'h00, 4'd0);
      script[3]  = mk_row(OP_SPARE_B,    4'd0,  8'h00, 1,  1'b1, 8'h00, 4'd0);
      script[4]  = mk_row(OP_PUSH_BACK,  4'd0,  8'h00, 1,  1'b1, 8'h00, 4'd1);
      script[5]  = mk_row(OP_PUSH_BACK,  4'd15, 8'hFF, 1,  1'b1, 8'h00, 4'd2);
      script[6]  = mk_row(OP_PUSH_FRONT, 4'd0,  8'hA5, 1,  1'b1, 8'h00, 4'd3);
      script[7]  = mk_row(OP_SET,        4'd1,  8'h5A, 1,  1'b1, 8'h00, 4'd3);
      script[8]  = mk_row(OP_GET,        4'd1,  8'h00, 1,  1'b1, 8'h5A, 4'd3);
      script[9]  = mk_row(OP_GET,        4'd0,  8'hFF, 1,  1'b1, 8'hA5, 4'd3);
      script[10] = mk_row(OP_POP_BACK,   4'd0,  8'h00, 1,  1'b1, 8'hFF, 4'd2);
      script[11] = mk_row(OP_POP_FRONT,  4'd0,  8'h00, 1,  1'b1, 8'hA5, 4'd1);
      script[12] = mk_row(OP_PUSH_BACK,  4'd0,  8'h10, 14, 1'b0, 8'h00, 4'd0);
      script[13] = mk_row(OP_PUSH_BACK,  4'd0,  8'h77, 1,  1'b1, 8'h00, 4'd15);
      script[14] = mk_row(OP_PUSH_FRONT, 4'd0,  8'h11, 1,  1'b1, 8'h00, 4'd15);
      script[15] = mk_row(OP_GET,        4'd0,  8'h00, 1,  1'b1, 8'h11, 4'd15);
      script[16] = mk_row(OP_GET,        4'd14, 8'h00, 1,  1'b0, 8'h00, 4'd0);
      script[17] = mk_row(OP_GET,        4'd15, 8'h00, 1,  1'b0, 8'h00, 4'd0);
      script[18] = mk_row(OP_SET,        4'd15, 8'hC3, 1,  1'b1, 8'h00, 4'd15);
      script[19] = mk_row(OP_GET,        4'd15, 8'h00, 1,  1'b1, 8'hC3, 4'd15);
      script[20] = mk_row(OP_SPARE_A,    4'd7,  8'h3C, 1,  1'b1, 8'h00, 4'd15);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         row_ans = script[r].ans;
         for (int k = 0; k < int'(script[r].reps); k++)
            offer_beat(script[r].op, script[r].off, script[r].val + VALUE_W'(k),
                       script[r].typed, row_ans);
      end

      // random traffic in fill and drain phases so full and empty recur
      real_items = 0;
      phase_left = 0;
      fill_phase = 1'b0;
      while (real_items < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            fill_phase = !fill_phase;
            phase_left = $urandom_range(8, 40);
         end
         phase_left--;
         live = live_entries();
         val  = VALUE_W'($urandom_range(0, 255));
         if (live > 0 && $urandom_range(0, 3) != 0)
            off = OFFSET_W'($urandom_range(0, live - 1));
         else
            off = OFFSET_W'($urandom_range(0, 15));
         pick = $urandom_range(0, 99);
         if (pick < 6)
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
         else if (pick < (fill_phase ? 60 : 26))
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         else if (pick < 80)
            op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
         else
            op = $urandom_range(0, 1) ? OP_GET : OP_SET;
         // never read a slot that was never written
         pos = head_ix + off;
         if (op == OP_GET && !written[pos]) op = OP_SET;
         real_items++;
         offer_beat(op, off, val, 1'b0, '0);
      end
      req_valid <= 1'b0;

      // drain, then watch a little longer for stray beats
      while (owed_answers.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
